FILE: rtl/rfc_pkg.sv
// rfc_pkg: shared types and constants for the regula falsi cubic root finder.
// No dependencies.
`default_nettype none
package rfc_pkg;
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOBRACKET = 2'd1;
	localparam logic [1:0] ST_LIMIT     = 2'd2;
	localparam logic [1:0] ST_ZERODIV   = 2'd3;

	localparam logic REG_TOLERANCE = 1'b0;
	localparam logic REG_LIMIT     = 1'b1;

	localparam int FW = 50;

	typedef enum logic [2:0] {
		OP_NONE, OP_LOAD, OP_FUNC_A, OP_FUNC_B, OP_FUNC_C, OP_DIV, OP_STEP, OP_UPDATE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic go;
	} rfc_cmd_t;

	typedef struct packed {
		logic done;
		logic bracketed;
		logic zero_den;
		logic converged;
	} rfc_stat_t;
endpackage
`default_nettype wire

FILE: rtl/regula_falsi_cubic_root.sv
// Regula falsi root finder for f(x) = x^3 - 2x - 5, signed fixed point.
// done rises after the bracket check for a pair that is not bracketed or flat, else after
// n steps (after the check that follows them, on a flat bracket);
// each step is the one-bit-per-cycle divider, the f evaluation and control.
// One item at a time; the next beat is taken at the edge that raises done. No receiver stall.
// Asynchronous active-low reset; tolerance resets to 66, limit to 1000.
`default_nettype none
module regula_falsi_cubic_root import rfc_pkg::*; #(
	parameter int DATA_WIDTH = 24,
	parameter int FRAC_BITS  = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire signed [DATA_WIDTH-1:0]  first_guess,
	input  wire signed [DATA_WIDTH-1:0]  second_guess,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [0:0]                   cfg_index,
	input  wire  [23:0]                  cfg_data,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] root,
	output logic signed [DATA_WIDTH-1:0] residual,
	output logic [15:0]                  iterations,
	output logic [1:0]                   status
);
	logic [23:0] tol_q;
	logic [15:0] lim_q;
	rfc_cmd_t    cmd;
	rfc_stat_t   stat;
	logic        fin;
	logic [1:0]  code;
	logic [15:0] count;
	logic signed [DATA_WIDTH-1:0] rt, rs;
	logic signed [DATA_WIDTH-1:0] ga_q, gb_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 24'd66;
			lim_q <= 16'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOLERANCE: tol_q <= cfg_data;
				REG_LIMIT:     lim_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			ga_q <= first_guess;
			gb_q <= second_guess;
		end
	end

	rfc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .limit(lim_q), .stat(stat),
		.cmd(cmd), .busy(busy), .fin(fin), .code(code), .count(count)
	);

	rfc_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .ga(ga_q), .gb(gb_q),
		.tol(tol_q), .stat(stat), .root(rt), .residual(rs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			status     <= code;
			iterations <= (code == ST_NOBRACKET) ? 16'd0 : count;
			root       <= (code == ST_NOBRACKET) ? '0 : rt;
			residual   <= (code == ST_NOBRACKET) ? '0 : rs;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/rfc_func.sv
// rfc_func: multicycle evaluation of f(x) = x^3 - 2x - 5, clamped to +-(2^48-1).
// Depends on rfc_pkg.
`default_nettype none
module rfc_func import rfc_pkg::*; #(
	parameter int DATA_WIDTH = 24,
	parameter int FRAC_BITS  = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire signed [DATA_WIDTH-1:0] x,
	output logic                        done,
	output logic signed [FW-1:0]        fx
);
	localparam int MW = 2 * DATA_WIDTH;
	localparam logic [63:0] CAP = 64'd1 << 50;
	localparam logic signed [FW+1:0] FMAX = (FW+2)'((64'd1 << 48) - 64'd1);

	logic [2:0]            ph_q;
	logic [DATA_WIDTH-1:0] m_q;
	logic [63:0]           sq_q;
	logic [63:0]           cube_q;
	logic                  neg_q;
	logic signed [DATA_WIDTH-1:0] x_q;
	logic [63:0]           hx;
	logic [63:0]           lo_p;
	logic [63:0]           cube_d;
	logic signed [FW+1:0]  r;

	assign hx   = (sq_q >> 32) * 64'(m_q);
	assign lo_p = (64'(sq_q[31:0]) * 64'(m_q)) >> FRAC_BITS;

	always_comb begin
		if (hx >= (64'd1 << (18 + FRAC_BITS))) begin
			cube_d = CAP;
		end else begin
			cube_d = (hx << (32 - FRAC_BITS)) + lo_p;
			if (cube_d > CAP) cube_d = CAP;
		end
	end

	always_comb begin
		r = neg_q ? -$signed({1'b0, cube_q[FW:0]}) : $signed({1'b0, cube_q[FW:0]});
		r = r - (FW+2)'(2 * $signed(64'(x_q))) - (FW+2)'(64'd5 << FRAC_BITS);
		if (r > FMAX) r = FMAX;
		if (r < -FMAX) r = -FMAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (ph_q)
				3'd0: if (start) ph_q <= 3'd1;
				3'd1: ph_q <= 3'd2;
				3'd2: ph_q <= 3'd3;
				3'd3: begin
					ph_q <= 3'd0;
					done <= 1'b1;
				end
				default: ph_q <= 3'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == 3'd0 && start) begin
			x_q   <= x;
			neg_q <= x[DATA_WIDTH-1];
			m_q   <= x[DATA_WIDTH-1] ? DATA_WIDTH'(-x) : DATA_WIDTH'(x);
		end
		if (ph_q == 3'd1) sq_q <= 64'((MW'(m_q) * MW'(m_q)) >> FRAC_BITS);
		if (ph_q == 3'd2) cube_q <= cube_d;
		if (ph_q == 3'd3) fx <= FW'(r);
	end
endmodule
`default_nettype wire

FILE: rtl/rfc_div.sv
// rfc_div: restoring divider, one quotient bit per cycle, q = floor(n*2^30/d).
// Depends on rfc_pkg.
`default_nettype none
module rfc_div import rfc_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [30:0] num,
	input  wire  [30:0] den,
	output logic        done,
	output logic [30:0] quot
);
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [31:0] rem_q;
	logic [60:0] sh_q;
	logic [30:0] den_q;
	logic [31:0] trial;

	assign trial = {rem_q[30:0], sh_q[60]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd61;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= {num, 30'd0};
			den_q <= den;
		end else if (run_q) begin
			sh_q <= {sh_q[59:0], ~trial[31]};
			rem_q <= trial[31] ? {rem_q[30:0], sh_q[60]} : trial;
		end
	end

	assign quot = sh_q[30:0];
endmodule
`default_nettype wire

FILE: rtl/rfc_datapath.sv
// rfc_datapath: endpoint registers, f evaluation, division and step arithmetic.
// Depends on rfc_pkg, rfc_func, rfc_div.
`default_nettype none
module rfc_datapath import rfc_pkg::*; #(
	parameter int DATA_WIDTH = 24,
	parameter int FRAC_BITS  = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  rfc_cmd_t                    cmd,
	input  wire signed [DATA_WIDTH-1:0] ga,
	input  wire signed [DATA_WIDTH-1:0] gb,
	input  wire [23:0]                  tol,
	output rfc_stat_t                   stat,
	output logic signed [DATA_WIDTH-1:0] root,
	output logic signed [DATA_WIDTH-1:0] residual
);
	localparam int SW = DATA_WIDTH + 2;
	localparam logic signed [FW-1:0] OHI = FW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);

	logic signed [SW-1:0]         a_q, b_q, c_q;
	logic signed [FW-1:0]         fa_q, fb_q, fc_q;
	logic [30:0]                  t_q;
	logic [DATA_WIDTH:0]          span_q;
	logic                         fstart, fdone, dstart, ddone;
	logic signed [DATA_WIDTH-1:0] fx_in;
	logic signed [FW-1:0]         fx;
	logic [30:0]                  q;
	logic [FW-1:0]                ma, mb, mc;
	logic [FW:0]                  den_d, num_d;
	logic [FW:0]                  den_s;
	logic [5:0]                   sh;
	logic [DATA_WIDTH+31:0]       prod;
	logic [DATA_WIDTH:0]          stp;
	logic signed [SW-1:0]         c_d;
	logic signed [SW-1:0]         diff;
	logic                         zero_den;

	assign ma = fa_q[FW-1] ? FW'(-fa_q) : FW'(fa_q);
	assign mb = fb_q[FW-1] ? FW'(-fb_q) : FW'(fb_q);
	assign mc = fc_q[FW-1] ? FW'(-fc_q) : FW'(fc_q);

	// scale both terms so the divisor fits in 31 bits
	always_comb begin
		den_s = (FW+1)'(ma) + (FW+1)'(mb);
		sh = '0;
		for (int i = 31; i <= FW; i++) begin
			if (den_s[i]) sh = 6'(i - 30);
		end
		num_d = {1'b0, ma} >> sh;
		den_d = den_s >> sh;
	end

	assign fx_in = (cmd.op == OP_FUNC_A) ? DATA_WIDTH'(a_q) :
		(cmd.op == OP_FUNC_B) ? DATA_WIDTH'(b_q) : DATA_WIDTH'(c_q);
	assign fstart = cmd.go && (cmd.op == OP_FUNC_A || cmd.op == OP_FUNC_B ||
		cmd.op == OP_FUNC_C);
	assign dstart = cmd.go && cmd.op == OP_DIV;

	rfc_func #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_func (
		.clk(clk), .arst_n(arst_n), .start(fstart), .x(fx_in), .done(fdone), .fx(fx)
	);
	rfc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(num_d[30:0]),
		.den(den_d[30:0]), .done(ddone), .quot(q)
	);

	assign diff = b_q - a_q;
	assign prod = (DATA_WIDTH+32)'(span_q) * (DATA_WIDTH+32)'(t_q) +
		(DATA_WIDTH+32)'(64'd1 << 29);
	assign stp  = (DATA_WIDTH+1)'(prod >> 30);
	assign c_d  = (b_q >= a_q) ? a_q + SW'(stp) : a_q - SW'(stp);

	logic busy_q;
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go && cmd.op != OP_NONE) busy_q <= 1'b1;
			if (busy_q && (fdone || ddone || cmd.op == OP_STEP || cmd.op == OP_UPDATE ||
				cmd.op == OP_LOAD)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			if (fdone || ddone) done_q <= 1'b1;
			if (cmd.go && (cmd.op == OP_LOAD || cmd.op == OP_STEP || cmd.op == OP_UPDATE))
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			unique case (cmd.op)
				OP_LOAD: begin
					a_q <= SW'(ga);
					b_q <= SW'(gb);
				end
				OP_DIV: begin
					span_q <= diff[SW-1] ? (DATA_WIDTH+1)'(-diff) : (DATA_WIDTH+1)'(diff);
				end
				OP_STEP: c_q <= c_d;
				OP_UPDATE: begin
					if ((fa_q < 0 && fc_q > 0) || (fa_q > 0 && fc_q < 0)) begin
						b_q  <= c_q;
						fb_q <= fc_q;
					end else begin
						a_q  <= c_q;
						fa_q <= fc_q;
					end
				end
				default: ;
			endcase
		end
		if (fdone) begin
			unique case (cmd.op)
				OP_FUNC_A: fa_q <= fx;
				OP_FUNC_B: fb_q <= fx;
				default:   fc_q <= fx;
			endcase
		end
		if (ddone) t_q <= q;
	end

	assign zero_den = (ma == '0) && (mb == '0);

	assign stat = '{
		done:      done_q,
		bracketed: !((fa_q > 0 && fb_q > 0) || (fa_q < 0 && fb_q < 0)),
		zero_den:  zero_den,
		converged: (mc < FW'(tol))
	};

	function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [FW-1:0] v);
		if (v > OHI) return DATA_WIDTH'(OHI);
		if (v < -OHI - 1) return DATA_WIDTH'(-OHI - 1);
		return DATA_WIDTH'(v);
	endfunction

	// flat bracket reports end a and its f
	assign root     = zero_den ? sat(FW'(a_q)) : sat(FW'(c_q));
	assign residual = zero_den ? sat(fa_q) : sat(fc_q);
endmodule
`default_nettype wire

FILE: rtl/rfc_ctrl.sv
// rfc_ctrl: sequencer for bracketing check, false-position loop and result strobe.
// Depends on rfc_pkg.
`default_nettype none
module rfc_ctrl import rfc_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [15:0] limit,
	input  rfc_stat_t   stat,
	output rfc_cmd_t    cmd,
	output logic        busy,
	output logic        fin,
	output logic [1:0]  code,
	output logic [15:0] count
);
	typedef enum logic [3:0] {
		S_IDLE, S_FA, S_FAW, S_FB, S_FBW, S_CHK, S_DIVW, S_STEP, S_FC, S_FCW, S_UPD, S_EVAL
	} state_t;
	state_t st_q;
	logic [15:0] lim;
	assign lim = (limit == '0) ? 16'd1 : limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			cmd   <= '{op: OP_NONE, go: 1'b0};
			busy  <= 1'b0;
			fin   <= 1'b0;
			code  <= ST_OK;
			count <= '0;
		end else begin
			cmd.go <= 1'b0;
			fin <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) begin
					busy  <= 1'b1;
					count <= '0;
					cmd   <= '{op: OP_LOAD, go: 1'b1};
					st_q  <= S_FA;
				end
				S_FA: begin
					cmd <= '{op: OP_FUNC_A, go: 1'b1};
					st_q <= S_FAW;
				end
				S_FAW: if (stat.done && !cmd.go) begin
					cmd <= '{op: OP_FUNC_B, go: 1'b1};
					st_q <= S_FBW;
				end
				S_FB: st_q <= S_FBW;
				S_FBW: if (stat.done && !cmd.go) st_q <= S_CHK;
				S_CHK: begin
					if (!stat.bracketed) begin
						code <= ST_NOBRACKET; fin <= 1'b1; busy <= 1'b0; st_q <= S_IDLE;
					end else if (stat.zero_den) begin
						code <= ST_ZERODIV; fin <= 1'b1; busy <= 1'b0; st_q <= S_IDLE;
					end else begin
						cmd <= '{op: OP_DIV, go: 1'b1};
						st_q <= S_DIVW;
					end
				end
				S_DIVW: if (stat.done && !cmd.go) begin
					cmd <= '{op: OP_STEP, go: 1'b1};
					st_q <= S_STEP;
				end
				S_STEP: begin
					cmd <= '{op: OP_FUNC_C, go: 1'b1};
					st_q <= S_FCW;
				end
				S_FC: st_q <= S_FCW;
				S_FCW: if (stat.done && !cmd.go) begin
					cmd <= '{op: OP_UPDATE, go: 1'b1};
					count <= count + 16'd1;
					st_q <= S_UPD;
				end
				S_UPD: st_q <= S_EVAL;
				S_EVAL: begin
					if (stat.converged) begin
						code <= ST_OK; fin <= 1'b1; busy <= 1'b0; st_q <= S_IDLE;
					end else if (count >= lim) begin
						code <= ST_LIMIT; fin <= 1'b1; busy <= 1'b0; st_q <= S_IDLE;
					end else st_q <= S_CHK;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) fin |-> !busy)
		else $error("busy after finish");
	assert property (@(posedge clk) disable iff (!arst_n) fin |-> $past(busy))
		else $error("finish while idle");
	assert property (@(posedge clk) disable iff (!arst_n) (st_q == S_EVAL) |-> count != '0)
		else $error("eval without a step");
endmodule
`default_nettype wire
